[rtl/prs_pkg.sv]
// Shared types, register codes and constants for the progress ring pixel shader.
// Depends on nothing; every other file of the block imports it.
package prs_pkg;

   localparam int COORD_BITS_DEFAULT = 12;
   localparam int ANGLE_BITS_DEFAULT = 16;

   localparam int PIXEL_BITS     = 32;
   localparam int COLOR_BITS     = 24;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_CENTER_X = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CENTER_Y = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RADIUS   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PROGRESS = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FILL     = 3'd4;

   localparam int         RING_THICKNESS = 3;
   localparam logic [7:0] ALPHA_OPAQUE   = 8'hFF;

   // CORDIC sizing beyond the output angle width
   localparam int CORDIC_EXTRA_STAGES = 28;
   localparam int CORDIC_FRAC_GUARD   = 30;
   localparam int CORDIC_ANGLE_GUARD  = 32;

   localparam real TWO_PI           = 6.283185307179586;
   localparam real TURNS_PER_RADIAN = 1.0 / TWO_PI;

   typedef enum logic [1:0] {
      KIND_CORDIC,
      KIND_ZERO,
      KIND_DIAG
   } angle_kind_type;

   typedef struct packed {
      logic                  ring_ok;
      logic [1:0]            quadrant;
      angle_kind_type        kind;
      logic [PIXEL_BITS-1:0] dest;
   } side_type;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] out_pixel;
      logic                  covered;
   } rsp_word_type;

   // atan(2^-idx) as a fraction of a full turn, scaled by 2^frac_bits
   function automatic logic [63:0] atan_turns(input int idx, input int frac_bits);
      real ang;
      real scaled;
      ang    = $atan(2.0 ** (-idx));
      scaled = ang * TURNS_PER_RADIAN * (2.0 ** frac_bits);
      return 64'(longint'(scaled));
   endfunction

endpackage

[rtl/prs_ifs.sv]
// Channel interfaces of the progress ring pixel shader: pixel request,
// shaded response and register write. Depends on prs_pkg.
interface prs_req_if #(
   parameter int COORD_BITS = prs_pkg::COORD_BITS_DEFAULT
);
   import prs_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] pixel_col;
   logic [COORD_BITS-1:0] pixel_row;
   logic [PIXEL_BITS-1:0] dest_pixel;

   modport source (output valid, output pixel_col, output pixel_row, output dest_pixel,
                   input ready);
   modport sink (input valid, input pixel_col, input pixel_row, input dest_pixel,
                 output ready);
endinterface

interface prs_rsp_if;
   import prs_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [PIXEL_BITS-1:0] out_pixel;
   logic                  covered;

   modport source (output valid, output out_pixel, output covered, input ready);
   modport sink (input valid, input out_pixel, input covered, output ready);
endinterface

interface prs_csr_if;
   import prs_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/prs_csr.sv]
// Configuration registers plus the derived squared ring bounds.
// Depends on prs_pkg and prs_csr_if.
module prs_csr #(
   parameter int COORD_BITS = prs_pkg::COORD_BITS_DEFAULT,
   parameter int ANGLE_BITS = prs_pkg::ANGLE_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   prs_csr_if.sink                           csr_chan,
   output logic signed [COORD_BITS-1:0]      center_x,
   output logic signed [COORD_BITS-1:0]      center_y,
   output logic [2*COORD_BITS-3:0]           radius_sq,
   output logic [2*COORD_BITS-3:0]           inner_sq,
   output logic [ANGLE_BITS:0]               progress,
   output logic [prs_pkg::COLOR_BITS-1:0]    fill_color
);
   import prs_pkg::*;

   localparam int RW = COORD_BITS - 1;

   logic signed [COORD_BITS-1:0] center_x_ff, center_y_ff;
   logic [RW-1:0]                radius_ff;
   logic [ANGLE_BITS:0]          progress_ff;
   logic [COLOR_BITS-1:0]        fill_ff;
   logic [2*RW-1:0]              radius_sq_ff, inner_sq_ff;
   logic [RW-1:0]                inner_in;
   logic [2*RW-1:0]              radius_sq_in, inner_sq_in;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         radius_ff   <= '0;
         progress_ff <= '0;
         fill_ff     <= '0;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_CENTER_X: center_x_ff <= csr_chan.data[COORD_BITS-1:0];
            CSR_CENTER_Y: center_y_ff <= csr_chan.data[COORD_BITS-1:0];
            CSR_RADIUS:   radius_ff   <= csr_chan.data[RW-1:0];
            CSR_PROGRESS: progress_ff <= csr_chan.data[ANGLE_BITS:0];
            CSR_FILL:     fill_ff     <= csr_chan.data[COLOR_BITS-1:0];
            default: ;
         endcase
      end
   end

   // inner radius clamps at zero
   always_comb begin
      if (radius_ff > RW'(RING_THICKNESS)) begin
         inner_in = radius_ff - RW'(RING_THICKNESS);
      end else begin
         inner_in = '0;
      end
      radius_sq_in = (2*RW)'(radius_ff * radius_ff);
      inner_sq_in  = (2*RW)'(inner_in * inner_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_sq_ff <= '0;
         inner_sq_ff  <= '0;
      end else begin
         radius_sq_ff <= radius_sq_in;
         inner_sq_ff  <= inner_sq_in;
      end
   end

   assign center_x   = center_x_ff;
   assign center_y   = center_y_ff;
   assign radius_sq  = radius_sq_ff;
   assign inner_sq   = inner_sq_ff;
   assign progress   = progress_ff;
   assign fill_color = fill_ff;

endmodule

[rtl/prs_front.sv]
// Front end: offsets from the center, squared distance ring test and quadrant fold.
// Three register stages; depends on prs_pkg and prs_req_if.
module prs_front #(
   parameter int COORD_BITS = prs_pkg::COORD_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   prs_req_if.sink                        req_chan,
   input  logic signed [COORD_BITS-1:0]   center_x,
   input  logic signed [COORD_BITS-1:0]   center_y,
   input  logic [2*COORD_BITS-3:0]        radius_sq,
   input  logic [2*COORD_BITS-3:0]        inner_sq,
   output logic                           out_valid,
   output logic [COORD_BITS:0]            out_a,
   output logic [COORD_BITS:0]            out_b,
   output prs_pkg::side_type              out_side
);
   import prs_pkg::*;

   localparam int DW  = COORD_BITS + 2;
   localparam int AW  = COORD_BITS + 1;
   localparam int SQW = 2 * COORD_BITS + 2;

   // stage 1: offsets
   logic                    v1_ff;
   logic signed [DW-1:0]    dx1_ff, dy1_ff;
   logic [PIXEL_BITS-1:0]   dest1_ff;
   logic signed [DW-1:0]    dx_in, dy_in;

   // stage 2: squares and fold
   logic                    v2_ff;
   logic [SQW-1:0]          dx2_ff, dy2_ff;
   logic [AW-1:0]           a2_ff, b2_ff;
   logic [1:0]              qn2_ff;
   angle_kind_type          kind2_ff;
   logic [PIXEL_BITS-1:0]   dest2_ff;
   logic signed [2*DW-1:0]  dx_sq, dy_sq;
   logic signed [DW-1:0]    ndx, ndy;
   logic [AW-1:0]           a_in, b_in;
   logic [1:0]              qn_in;
   angle_kind_type          kind_in;

   // stage 3: ring test
   logic                    v3_ff;
   logic [AW-1:0]           a3_ff, b3_ff;
   side_type                side3_ff;
   logic [SQW:0]            d2;
   logic                    ring_in;

   assign req_chan.ready = en;

   assign dx_in = $signed({2'b00, req_chan.pixel_col}) - DW'(center_x);
   assign dy_in = $signed({2'b00, req_chan.pixel_row}) - DW'(center_y);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx1_ff   <= dx_in;
         dy1_ff   <= dy_in;
         dest1_ff <= req_chan.dest_pixel;
      end
   end

   assign dx_sq = dx1_ff * dx1_ff;
   assign dy_sq = dy1_ff * dy1_ff;
   assign ndx   = -dx1_ff;
   assign ndy   = -dy1_ff;

   // fold into a quadrant: angle of (a, b) from the quadrant's start, clockwise
   always_comb begin
      if (dx1_ff == '0 && dy1_ff == '0) begin
         qn_in = 2'd1;
         a_in  = '0;
         b_in  = '0;
      end else if (!dx1_ff[DW-1] && dy1_ff[DW-1]) begin
         qn_in = 2'd0;
         a_in  = ndy[AW-1:0];
         b_in  = dx1_ff[AW-1:0];
      end else if (dx1_ff > 0 && !dy1_ff[DW-1]) begin
         qn_in = 2'd1;
         a_in  = dx1_ff[AW-1:0];
         b_in  = dy1_ff[AW-1:0];
      end else if (dx1_ff <= 0 && dy1_ff > 0) begin
         qn_in = 2'd2;
         a_in  = dy1_ff[AW-1:0];
         b_in  = ndx[AW-1:0];
      end else begin
         qn_in = 2'd3;
         a_in  = ndx[AW-1:0];
         b_in  = ndy[AW-1:0];
      end
      if (b_in == '0) begin
         kind_in = KIND_ZERO;
      end else if (b_in == a_in) begin
         kind_in = KIND_DIAG;
      end else begin
         kind_in = KIND_CORDIC;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx2_ff   <= dx_sq[SQW-1:0];
         dy2_ff   <= dy_sq[SQW-1:0];
         a2_ff    <= a_in;
         b2_ff    <= b_in;
         qn2_ff   <= qn_in;
         kind2_ff <= kind_in;
         dest2_ff <= dest1_ff;
      end
   end

   assign d2      = {1'b0, dx2_ff} + {1'b0, dy2_ff};
   assign ring_in = (d2 <= (SQW+1)'(radius_sq)) && (d2 >= (SQW+1)'(inner_sq));

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a3_ff             <= a2_ff;
         b3_ff             <= b2_ff;
         side3_ff.ring_ok  <= ring_in;
         side3_ff.quadrant <= qn2_ff;
         side3_ff.kind     <= kind2_ff;
         side3_ff.dest     <= dest2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign out_a     = a3_ff;
   assign out_b     = b3_ff;
   assign out_side  = side3_ff;

   a_cordic_operands: assert property (@(posedge clock) disable iff (reset)
      v3_ff && side3_ff.kind == KIND_CORDIC |-> a3_ff != '0 && b3_ff != '0 && a3_ff != b3_ff)
      else $error("front: CORDIC word with degenerate operands");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !en && v3_ff |=> v3_ff && $stable(a3_ff) && $stable(b3_ff) && $stable(side3_ff))
      else $error("front: last stage changed during a stall");

endmodule

[rtl/prs_cordic.sv]
// Vectoring CORDIC pipeline: one micro-rotation per stage, angle kept in turns.
// Carries the side word alongside; depends on prs_pkg.
module prs_cordic #(
   parameter int COORD_BITS = prs_pkg::COORD_BITS_DEFAULT,
   parameter int ANGLE_BITS = prs_pkg::ANGLE_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  logic [COORD_BITS:0]       in_a,
   input  logic [COORD_BITS:0]       in_b,
   input  prs_pkg::side_type         in_side,
   output logic                      out_valid,
   output logic [ANGLE_BITS-3:0]     out_sub,
   output prs_pkg::side_type         out_side
);
   import prs_pkg::*;

   localparam int NS = ANGLE_BITS + CORDIC_EXTRA_STAGES;
   localparam int FB = ANGLE_BITS + CORDIC_FRAC_GUARD;
   localparam int ZF = ANGLE_BITS + CORDIC_ANGLE_GUARD;
   localparam int XW = COORD_BITS + 3 + FB;
   localparam int ZW = ZF + 1;

   logic                 v_ff [NS];
   logic signed [XW-1:0] x_ff [NS];
   logic signed [XW-1:0] y_ff [NS];
   logic signed [ZW-1:0] z_ff [NS];
   side_type             s_ff [NS];

   for (genvar i = 0; i < NS; i++) begin : g_stage
      localparam logic signed [ZW-1:0] ANG = ZW'(atan_turns(i, ZF));

      logic                 v_cur;
      logic signed [XW-1:0] x_cur, y_cur, x_in, y_in;
      logic signed [ZW-1:0] z_cur, z_in;
      side_type             s_cur;

      if (i == 0) begin : g_first
         assign v_cur = in_valid;
         assign x_cur = $signed({2'b00, in_a, {FB{1'b0}}});
         assign y_cur = $signed({2'b00, in_b, {FB{1'b0}}});
         assign z_cur = '0;
         assign s_cur = in_side;
      end else begin : g_next
         assign v_cur = v_ff[i-1];
         assign x_cur = x_ff[i-1];
         assign y_cur = y_ff[i-1];
         assign z_cur = z_ff[i-1];
         assign s_cur = s_ff[i-1];
      end

      // rotate toward the x axis; the sign of y picks the direction
      always_comb begin
         if (y_cur[XW-1]) begin
            x_in = x_cur - (y_cur >>> i);
            y_in = y_cur + (x_cur >>> i);
            z_in = z_cur - ANG;
         end else begin
            x_in = x_cur + (y_cur >>> i);
            y_in = y_cur - (x_cur >>> i);
            z_in = z_cur + ANG;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (en) begin
            v_ff[i] <= v_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i] <= x_in;
            y_ff[i] <= y_in;
            z_ff[i] <= z_in;
            s_ff[i] <= s_cur;
         end
      end
   end

   assign out_valid = v_ff[NS-1];
   assign out_sub   = z_ff[NS-1][ZF-3:ZF-ANGLE_BITS];
   assign out_side  = s_ff[NS-1];

endmodule

[rtl/progress_ring_pixel_shader.sv]
// Progress ring pixel shader, top level. Pipeline from accept to response: three front
// stages, one stage per CORDIC micro-rotation (ANGLE_BITS + 28 of them) and the output
// register. Throughput one pixel per clock while the skid word is free.
// A two-word output buffer takes the last result while the sink stalls.
// Reset clears all valid bits and every configuration register to zero.
module progress_ring_pixel_shader #(
   parameter int COORD_BITS = prs_pkg::COORD_BITS_DEFAULT,
   parameter int ANGLE_BITS = prs_pkg::ANGLE_BITS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   prs_req_if.sink   req_chan,
   prs_rsp_if.source rsp_chan,
   prs_csr_if.sink   csr_chan
);
   import prs_pkg::*;

   localparam int AW = COORD_BITS + 1;

   logic signed [COORD_BITS-1:0] center_x, center_y;
   logic [2*COORD_BITS-3:0]      radius_sq, inner_sq;
   logic [ANGLE_BITS:0]          progress;
   logic [COLOR_BITS-1:0]        fill_color;

   logic                         en;
   logic                         front_valid;
   logic [AW-1:0]                front_a, front_b;
   side_type                     front_side;
   logic                         cordic_valid;
   logic [ANGLE_BITS-3:0]        cordic_sub;
   side_type                     cordic_side;

   logic [ANGLE_BITS-3:0]        sub_sel;
   logic [ANGLE_BITS-1:0]        turn_frac;
   logic                         hit;
   rsp_word_type                 res;

   logic                         out_valid_ff, out_valid_in;
   rsp_word_type                 out_ff, out_in;
   logic                         skid_valid_ff, skid_valid_in;
   rsp_word_type                 skid_ff, skid_in;
   logic                         take;

   prs_csr #(
      .COORD_BITS (COORD_BITS),
      .ANGLE_BITS (ANGLE_BITS)
   ) u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_chan   (csr_chan),
      .center_x   (center_x),
      .center_y   (center_y),
      .radius_sq  (radius_sq),
      .inner_sq   (inner_sq),
      .progress   (progress),
      .fill_color (fill_color)
   );

   prs_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .req_chan  (req_chan),
      .center_x  (center_x),
      .center_y  (center_y),
      .radius_sq (radius_sq),
      .inner_sq  (inner_sq),
      .out_valid (front_valid),
      .out_a     (front_a),
      .out_b     (front_b),
      .out_side  (front_side)
   );

   prs_cordic #(
      .COORD_BITS (COORD_BITS),
      .ANGLE_BITS (ANGLE_BITS)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (front_valid),
      .in_a      (front_a),
      .in_b      (front_b),
      .in_side   (front_side),
      .out_valid (cordic_valid),
      .out_sub   (cordic_sub),
      .out_side  (cordic_side)
   );

   // axes and exact diagonals take their exact fractions
   always_comb begin
      case (cordic_side.kind)
         KIND_ZERO: sub_sel = '0;
         KIND_DIAG: sub_sel = (ANGLE_BITS-2)'(1) << (ANGLE_BITS - 3);
         default:   sub_sel = cordic_sub;
      endcase
      turn_frac     = {cordic_side.quadrant, sub_sel};
      hit           = cordic_side.ring_ok && (progress != '0)
                      && ({1'b0, turn_frac} <= progress);
      res.covered   = hit;
      res.out_pixel = hit ? {ALPHA_OPAQUE, fill_color} : cordic_side.dest;
   end

   // the pipeline runs while the skid word is free
   assign en   = !skid_valid_ff;
   assign take = out_valid_ff && rsp_chan.ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (cordic_valid) begin
         if (!out_valid_ff || take) begin
            out_in       = res;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = res;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.out_pixel = out_ff.out_pixel;
   assign rsp_chan.covered   = out_ff.covered;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("top: skid word held without an output word");

   a_covered_opaque: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.covered |-> out_ff.out_pixel[31:24] == ALPHA_OPAQUE)
      else $error("top: covered pixel without opaque alpha");

   a_stall_fills_skid: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_chan.ready && !skid_valid_ff && cordic_valid |=> skid_valid_ff)
      else $error("top: arriving word dropped while the sink stalled");

endmodule

[tb/sv/progress_ring_pixel_shader_checker.sv]
`timescale 1ns / 100ps
// Checker for the progress ring pixel shader: tracks register writes, predicts each shaded
// pixel word and compares it with the response channel in order. Depends on prs_pkg.
module progress_ring_pixel_shader_checker #(
   parameter int COORD_BITS = prs_pkg::COORD_BITS_DEFAULT,
   parameter int ANGLE_BITS = prs_pkg::ANGLE_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic [COORD_BITS-1:0]              req_col,
   input  logic [COORD_BITS-1:0]              req_row,
   input  logic [prs_pkg::PIXEL_BITS-1:0]     req_dest,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic [prs_pkg::PIXEL_BITS-1:0]     rsp_pixel,
   input  logic                               rsp_covered,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [prs_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [prs_pkg::CSR_DATA_BITS-1:0]  csr_data,
   output int                                 fail_count,
   output int                                 outstanding
);
   import prs_pkg::*;

   // pi in Q60 radians: one turn in Q59
   localparam longint unsigned TURN_Q59 = 64'h3243F6A8885A308D;

   logic signed [COORD_BITS-1:0] ring_cx;
   logic signed [COORD_BITS-1:0] ring_cy;
   logic [COORD_BITS-2:0]        ring_radius;
   logic [ANGLE_BITS:0]          sweep;
   logic [COLOR_BITS-1:0]        fill;
   rsp_word_type                 shaded_q[$];

   // floor(t * m / d), exact for d below 2^40 and m <= d
   function automatic longint unsigned scaled_quot(input longint unsigned t,
                                                   input longint unsigned m,
                                                   input longint unsigned d);
      longint unsigned q, r, hq, s;
      int i;
      q  = t / d;
      r  = t % d;
      hq = 0;
      s  = 0;
      for (i = 39; i >= 0; i--) begin
         hq = hq << 1;
         s  = s << 1;
         if (s >= d) begin
            s  -= d;
            hq++;
         end
         if (m[i]) begin
            s += r;
            if (s >= d) begin
               s  -= d;
               hq++;
            end
         end
      end
      return q * m + hq;
   endfunction

   // floor(atan(b/a) / 2pi * 2^ANGLE_BITS) for 0 < b < a, by the Euler series of atan
   function automatic longint unsigned octant_turns(input longint unsigned a,
                                                    input longint unsigned b);
      longint unsigned den, w, term, sum, q, rem;
      int n, i;
      den  = a * a + b * b;
      w    = b * b;
      term = scaled_quot(64'd1 << 60, a * b, den);
      sum  = term;
      for (n = 1; n < 70 && term != 0; n++) begin
         term = scaled_quot(term, 2 * n, 2 * n + 1);
         term = scaled_quot(term, w, den);
         sum += term;
      end
      q   = sum / TURN_Q59;
      rem = sum % TURN_Q59;
      for (i = 0; i < ANGLE_BITS - 1; i++) begin
         rem = rem << 1;
         q   = q << 1;
         if (rem >= TURN_Q59) begin
            rem -= TURN_Q59;
            q++;
         end
      end
      return q;
   endfunction

   // clockwise turn fraction from straight up; the center counts as pointing right
   function automatic longint unsigned turn_fraction(input longint dx, input longint dy);
      longint unsigned quarter, qn, sub;
      longint a, b;
      quarter = 64'd1 << (ANGLE_BITS - 2);
      if (dx == 0 && dy == 0) return quarter;
      if (dx >= 0 && dy < 0) begin
         qn = 0; a = -dy; b = dx;
      end else if (dx > 0 && dy >= 0) begin
         qn = 1; a = dx; b = dy;
      end else if (dx <= 0 && dy > 0) begin
         qn = 2; a = dy; b = -dx;
      end else begin
         qn = 3; a = -dx; b = -dy;
      end
      if (b == 0) sub = 0;
      else if (b == a) sub = quarter / 2;
      else if (b < a) sub = octant_turns(a, b);
      else sub = quarter - octant_turns(b, a) - 1;
      return qn * quarter + sub;
   endfunction

   function automatic rsp_word_type shade_pixel(input logic [COORD_BITS-1:0] col,
                                                input logic [COORD_BITS-1:0] row,
                                                input logic [PIXEL_BITS-1:0] dest);
      longint dx, dy, r, inner, d2;
      longint unsigned limit;
      logic hit;
      rsp_word_type word;
      dx    = longint'(col) - longint'(ring_cx);
      dy    = longint'(row) - longint'(ring_cy);
      r     = longint'(ring_radius);
      inner = (r > RING_THICKNESS) ? r - RING_THICKNESS : 0;
      d2    = dx * dx + dy * dy;
      limit = longint'(sweep);
      if (limit > (64'd1 << ANGLE_BITS)) limit = 64'd1 << ANGLE_BITS;
      hit = 1'b0;
      if (limit != 0 && d2 <= r * r && d2 >= inner * inner)
         hit = (turn_fraction(dx, dy) <= limit);
      word.covered   = hit;
      word.out_pixel = hit ? {ALPHA_OPAQUE, fill} : dest;
      return word;
   endfunction

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         ring_cx     = '0;
         ring_cy     = '0;
         ring_radius = '0;
         sweep       = '0;
         fill        = '0;
         shaded_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CENTER_X: ring_cx     = csr_data[COORD_BITS-1:0];
               CSR_CENTER_Y: ring_cy     = csr_data[COORD_BITS-1:0];
               CSR_RADIUS:   ring_radius = csr_data[COORD_BITS-2:0];
               CSR_PROGRESS: sweep       = csr_data[ANGLE_BITS:0];
               CSR_FILL:     fill        = csr_data[COLOR_BITS-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            shaded_q.push_back(shade_pixel(req_col, req_row, req_dest));
         if (rsp_valid && rsp_ready) begin
            if (shaded_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected pixel word: out_pixel %h covered %b",
                           rsp_pixel, rsp_covered);
            end else begin
               want = shaded_q.pop_front();
               if (want.out_pixel !== rsp_pixel || want.covered !== rsp_covered) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("pixel word mismatch: expected %h covered %b, got %h covered %b",
                              want.out_pixel, want.covered, rsp_pixel, rsp_covered);
               end
            end
         end
      end
      outstanding <= shaded_q.size();
   end

endmodule

[tb/sv/progress_ring_pixel_shader_tb.sv]
`timescale 1ns / 100ps
// Top of the progress ring pixel shader testbench: clock, reset, register setup and pixel
// stimulus, with the checker beside the block. Depends on prs_pkg, prs_ifs and the checker.
module progress_ring_pixel_shader_tb;
   import prs_pkg::*;

   localparam int COORD_BITS = COORD_BITS_DEFAULT;
   localparam int ANGLE_BITS = ANGLE_BITS_DEFAULT;
   localparam int COORD_MAX  = (1 << COORD_BITS) - 1;
   localparam int FULL_TURN  = 1 << ANGLE_BITS;

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   calm  = 1'b0;
   int   ring_cx, ring_cy, ring_r;
   int   fail_count, outstanding;
   int   sent;

   prs_req_if #(.COORD_BITS(COORD_BITS)) pixel_req ();
   prs_rsp_if                            pixel_rsp ();
   prs_csr_if                            ring_csr ();

   progress_ring_pixel_shader #(
      .COORD_BITS(COORD_BITS),
      .ANGLE_BITS(ANGLE_BITS)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (pixel_req),
      .rsp_chan (pixel_rsp),
      .csr_chan (ring_csr)
   );

   progress_ring_pixel_shader_checker #(
      .COORD_BITS(COORD_BITS),
      .ANGLE_BITS(ANGLE_BITS)
   ) shade_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (pixel_req.valid),
      .req_ready   (pixel_req.ready),
      .req_col     (pixel_req.pixel_col),
      .req_row     (pixel_req.pixel_row),
      .req_dest    (pixel_req.dest_pixel),
      .rsp_valid   (pixel_rsp.valid),
      .rsp_ready   (pixel_rsp.ready),
      .rsp_pixel   (pixel_rsp.out_pixel),
      .rsp_covered (pixel_rsp.covered),
      .csr_valid   (ring_csr.valid),
      .csr_ready   (ring_csr.ready),
      .csr_index   (ring_csr.index),
      .csr_data    (ring_csr.data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always #4 clock = ~clock;

   // fill bits above the register width with noise
   function automatic logic [CSR_DATA_BITS-1:0] with_junk(input logic [31:0] value,
                                                          input int bits);
      logic [31:0] mask;
      mask = (bits >= 32) ? '1 : ((32'd1 << bits) - 1);
      return ($urandom() & ~mask) | (value & mask);
   endfunction

   // hold valid across back-to-back words; drop it only when a gap is drawn
   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         ring_csr.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      ring_csr.valid <= 1'b1;
      ring_csr.index <= idx;
      ring_csr.data  <= value;
      do @(posedge clock); while (!ring_csr.ready);
   endtask

   task automatic send_pixel(input int col, input int row, input logic [31:0] dest);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         pixel_req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      pixel_req.valid      <= 1'b1;
      pixel_req.pixel_col  <= COORD_BITS'(col);
      pixel_req.pixel_row  <= COORD_BITS'(row);
      pixel_req.dest_pixel <= dest;
      do @(posedge clock); while (!pixel_req.ready);
   endtask

   // stop sending and wait until every predicted word has come back
   task automatic drain();
      pixel_req.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic program_ring(input int cx, input int cy, input int r, input int prog,
                               input logic [31:0] color);
      drain();
      write_reg(CSR_CENTER_X, with_junk(cx, COORD_BITS));
      write_reg(CSR_CENTER_Y, with_junk(cy, COORD_BITS));
      write_reg(CSR_RADIUS, with_junk(r, COORD_BITS - 1));
      write_reg(CSR_PROGRESS, with_junk(prog, ANGLE_BITS + 1));
      write_reg(CSR_FILL, with_junk(color, COLOR_BITS));
      // indexes past the last register must be ignored
      if ($urandom_range(0, 2) == 0)
         write_reg(CSR_FILL + CSR_INDEX_BITS'($urandom_range(1, 3)), $urandom());
      ring_csr.valid <= 1'b0;
      ring_cx = cx;
      ring_cy = cy;
      ring_r  = r;
   endtask

   // mostly points on or just beside the ring, some on axes and diagonals, some noise
   task automatic ring_pixel(output int col, output int row);
      int dx, dy, span, tries;
      for (tries = 0; tries < 8; tries++) begin
         case ($urandom_range(0, 9))
            0, 1: begin
               col = $urandom_range(0, COORD_MAX);
               row = $urandom_range(0, COORD_MAX);
               return;
            end
            2: begin
               dx = $urandom_range(0, ring_r);
               dy = $urandom_range(0, 1) ? dx : 0;
            end
            default: begin
               dx   = int'($urandom_range(0, 2 * ring_r + 4)) - ring_r - 2;
               span = ring_r * ring_r - dx * dx;
               dy   = (span > 0) ? int'($floor($sqrt(real'(span)))) : 0;
               dy   = dy + 1 - int'($urandom_range(0, 4));
            end
         endcase
         if ($urandom_range(0, 1)) dx = -dx;
         if ($urandom_range(0, 1)) dy = -dy;
         if ($urandom_range(0, 1)) begin
            span = dx;
            dx   = dy;
            dy   = span;
         end
         col = ring_cx + dx;
         row = ring_cy + dy;
         if (col >= 0 && col <= COORD_MAX && row >= 0 && row <= COORD_MAX) return;
      end
      col = $urandom_range(0, COORD_MAX);
      row = $urandom_range(0, COORD_MAX);
   endtask

   // response sink with random stalls per word
   initial begin
      int stall;
      pixel_rsp.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = calm ? 0 : $urandom_range(0, 7);
         if (stall != 0) begin
            pixel_rsp.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         pixel_rsp.ready <= 1'b1;
         do @(posedge clock); while (!pixel_rsp.valid);
      end
   end

   initial begin
      int col, row, cx, cy, r, prog, items;
      pixel_req.valid      <= 1'b0;
      pixel_req.pixel_col  <= '0;
      pixel_req.pixel_row  <= '0;
      pixel_req.dest_pixel <= '0;
      ring_csr.valid       <= 1'b0;
      ring_csr.index       <= '0;
      ring_csr.data        <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // full circle: axes, diagonals, center, ring edges, field extremes
      program_ring(100, 100, 10, FULL_TURN, 32'h00123456);
      send_pixel(100, 100, $urandom());
      send_pixel(100, 90, $urandom());
      send_pixel(110, 100, $urandom());
      send_pixel(100, 110, $urandom());
      send_pixel(90, 100, $urandom());
      send_pixel(107, 93, $urandom());
      send_pixel(107, 107, $urandom());
      send_pixel(93, 107, $urandom());
      send_pixel(93, 93, $urandom());
      send_pixel(100, 93, $urandom());
      send_pixel(100, 94, $urandom());
      send_pixel(0, 0, 32'h0000_0000);
      send_pixel(COORD_MAX, COORD_MAX, 32'hFFFF_FFFF);

      // small ring with no hole, sweep ends exactly at 3 o'clock
      program_ring(5, 5, 3, FULL_TURN / 4, $urandom());
      send_pixel(5, 5, $urandom());
      send_pixel(8, 5, $urandom());
      send_pixel(5, 2, $urandom());
      send_pixel(5, 8, $urandom());

      // extreme centers and radius, oversized progress saturates
      program_ring(-2048, -2048, 2047, 2 * FULL_TURN - 1, $urandom());
      send_pixel(0, 0, $urandom());
      program_ring(2047, 2047, 2047, 2 * FULL_TURN - 1, $urandom());
      send_pixel(0, 2047, $urandom());
      send_pixel(2047, 0, $urandom());
      send_pixel(4094, 2047, $urandom());
      send_pixel(2047, 4094, $urandom());

      // zero progress draws nothing
      program_ring(100, 100, 10, 0, $urandom());
      send_pixel(110, 100, $urandom());

      sent = 0;
      while (sent < 1400) begin
         calm = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 7))
            0:       r = $urandom_range(0, 3);
            1:       r = $urandom_range(0, 2047);
            default: r = $urandom_range(4, 80);
         endcase
         if ($urandom_range(0, 4) == 0) begin
            cx = int'($urandom_range(0, 4095)) - 2048;
            cy = int'($urandom_range(0, 4095)) - 2048;
         end else begin
            cx = $urandom_range(0, 2047);
            cy = $urandom_range(0, 2047);
         end
         case ($urandom_range(0, 7))
            0:       prog = 0;
            1:       prog = FULL_TURN;
            2:       prog = $urandom_range(FULL_TURN + 1, 2 * FULL_TURN - 1);
            3:       prog = $urandom_range(1, 64);
            default: prog = $urandom_range(1, FULL_TURN - 1);
         endcase
         program_ring(cx, cy, r, prog, $urandom());
         items = $urandom_range(8, 60);
         repeat (items) begin
            ring_pixel(col, row);
            send_pixel(col, row, $urandom());
         end
         sent += items;
      end

      calm = 1'b0;
      drain();
      repeat (64) @(posedge clock);
      if (fail_count == 0)
         $display("progress_ring_pixel_shader_tb OK");
      else
         $display("progress_ring_pixel_shader_tb NOT OK");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("progress_ring_pixel_shader_tb NOT OK");
      $finish;
   end

endmodule
